// ===== src/ubx_pkg.sv =====
// shared types and constants for the binary frame parser
// no dependencies; imported by every module of the block
package ubx_pkg;

	// payload buffer size; bytes at or above this index are not kept
	localparam int unsigned BUFFER_BYTES = 512;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// word queue between the front and the back
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// one received word after classification
	typedef struct packed {
		logic [7:0] data;
		logic       sync1;
		logic       sync2;
	} ubx_word_t;

	// queue head as seen by the back
	typedef struct packed {
		logic      valid;
		ubx_word_t word;
	} ubx_head_t;

endpackage

// ===== src/ubx_front.sv =====
// input side: accepts received words, tags sync bytes, queues them
// depends on ubx_pkg
module ubx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output ubx_pkg::ubx_head_t head,
	input  logic             pop
);
	import ubx_pkg::*;

	ubx_word_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 push;
	ubx_word_t            new_word;

	assign in_stall = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign push     = in_valid && !in_stall;

	always_comb begin
		new_word.data  = rx_byte;
		new_word.sync1 = (rx_byte == SYNC_FIRST);
		new_word.sync2 = (rx_byte == SYNC_SECOND);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.word  = mem_q[rd_ptr_q];

endmodule

// ===== src/ubx_back.sv =====
// parse side: frame state machine, fletcher sums and the result register
// depends on ubx_pkg
module ubx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ubx_pkg::ubx_head_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               payload_strobe,
	output logic [7:0]         payload_byte,
	output logic [15:0]        payload_index,
	output logic               within_buffer,
	output logic               frame_done,
	output logic               frame_good,
	output logic [7:0]         msg_class,
	output logic [7:0]         msg_id,
	output logic [15:0]        payload_length,
	output logic [9:0]         stored_count
);
	import ubx_pkg::*;

	localparam logic [3:0] PH_SYNC1  = 4'd0;
	localparam logic [3:0] PH_SYNC2  = 4'd1;
	localparam logic [3:0] PH_CLASS  = 4'd2;
	localparam logic [3:0] PH_ID     = 4'd3;
	localparam logic [3:0] PH_LEN_LO = 4'd4;
	localparam logic [3:0] PH_LEN_HI = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_CK_A   = 4'd7;
	localparam logic [3:0] PH_CK_B   = 4'd8;

	localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] length_q, length_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] index_q, index_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic        out_valid_q;

	logic [7:0]  b;
	logic        strobe_d, within_d, done_d, good_d;
	logic [16:0] stored_w;
	logic [7:0]  acc_a;

	assign pop = head.valid && (!out_valid_q || !out_stall);
	assign b   = head.word.data;
	assign acc_a = sum_a_q + b;

	always_comb begin
		phase_d     = phase_q;
		class_d     = class_q;
		id_d        = id_q;
		length_d    = length_q;
		remaining_d = remaining_q;
		index_d     = index_q;
		sum_a_d     = sum_a_q;
		sum_b_d     = sum_b_q;
		strobe_d    = 1'b0;
		within_d    = 1'b0;
		done_d      = 1'b0;
		good_d      = 1'b0;
		unique case (phase_q)
			PH_SYNC2: begin
				if (head.word.sync2) begin
					phase_d = PH_CLASS;
				end else if (!head.word.sync1) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_CLASS: begin
				class_d = b;
				sum_a_d = b;
				sum_b_d = b;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = b;
				sum_a_d = acc_a;
				sum_b_d = sum_b_q + acc_a;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'h00, b};
				sum_a_d  = acc_a;
				sum_b_d  = sum_b_q + acc_a;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d    = {b, length_q[7:0]};
				remaining_d = {b, length_q[7:0]};
				index_d     = '0;
				sum_a_d     = acc_a;
				sum_b_d     = sum_b_q + acc_a;
				// empty payload skips straight to the check bytes
				phase_d     = ({b, length_q[7:0]} == 16'h0000) ? PH_CK_A : PH_DATA;
			end
			PH_DATA: begin
				sum_a_d     = acc_a;
				sum_b_d     = sum_b_q + acc_a;
				strobe_d    = 1'b1;
				within_d    = ({1'b0, index_q} < BUF_LIMIT);
				if (index_q != 16'hFFFF) begin
					index_d = index_q + 16'd1;
				end
				remaining_d = remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				// a bad first check byte drops the frame without a flag
				phase_d = (b == sum_a_q) ? PH_CK_B : PH_SYNC1;
			end
			PH_CK_B: begin
				done_d  = 1'b1;
				good_d  = (b == sum_b_q);
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = head.word.sync1 ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	assign stored_w = ({1'b0, index_d} > BUF_LIMIT) ? BUF_LIMIT : {1'b0, index_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC1;
			class_q     <= '0;
			id_q        <= '0;
			length_q    <= '0;
			remaining_q <= '0;
			index_q     <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				class_q     <= class_d;
				id_q        <= id_d;
				length_q    <= length_d;
				remaining_q <= remaining_d;
				index_q     <= index_d;
				sum_a_q     <= sum_a_d;
				sum_b_q     <= sum_b_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded only when the previous word has gone
	always_ff @(posedge clk) begin
		if (pop) begin
			payload_strobe <= strobe_d;
			payload_byte   <= strobe_d ? b : 8'h00;
			payload_index  <= strobe_d ? index_q : 16'h0000;
			within_buffer  <= within_d;
			frame_done     <= done_d;
			frame_good     <= good_d;
			msg_class      <= class_d;
			msg_id         <= id_d;
			payload_length <= length_d;
			stored_count   <= stored_w[9:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/ubx_frame_parser.sv =====
// top level of the binary frame parser: queueing front plus parsing back
// depends on ubx_pkg, ubx_front and ubx_back
//
// usage
// - input channel: one received word per handshake on rx_byte, taken at an edge
//   where in_valid is high and in_stall is low
// - output channel: exactly one result word per input word, in order; a result
//   is taken at an edge where out_valid is high and out_stall is low
// - frames are b5 62, class, id, 16-bit little-endian length, payload and two
//   fletcher-8 check bytes; payload bytes come out strobed with their index,
//   the second check byte raises frame_done with frame_good
// - a word accepted at an edge is written into the queue; the back pops it into the
//   result register, which raises out_valid and holds it until the result is taken
// - throughput: one word per cycle sustained while out_stall stays low; the parse
//   state updates once per word, so the frame state machine sets the rate
// - a four-word queue sits between the front and the back; when the receiver
//   stalls, the result register holds, the queue fills and in_stall rises once
//   it is full; no word is lost or repeated
// - reset (arst_n low) empties the queue, drops any pending result and puts the
//   parser back to hunting for the first sync byte with all fields cleared
module ubx_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_strobe,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic        within_buffer,
	output logic        frame_done,
	output logic        frame_good,
	output logic [7:0]  msg_class,
	output logic [7:0]  msg_id,
	output logic [15:0] payload_length,
	output logic [9:0]  stored_count
);
	import ubx_pkg::*;

	// queue head handed to the parser, and its pop back to the queue
	ubx_head_t head;
	logic      pop;

	ubx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.head     (head),
		.pop      (pop)
	);

	ubx_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_strobe (payload_strobe),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.within_buffer  (within_buffer),
		.frame_done     (frame_done),
		.frame_good     (frame_good),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.stored_count   (stored_count)
	);

endmodule

// ===== src/ubx_checker.sv =====
// port-level checks for the binary frame parser, bound to the top level
// depends on ubx_pkg and ubx_frame_parser
module ubx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        payload_strobe,
	input logic [7:0]  payload_byte,
	input logic [15:0] payload_index,
	input logic        within_buffer,
	input logic        frame_done,
	input logic        frame_good
);
	import ubx_pkg::*;

	// a good flag only ever comes with the end of a frame
	a_good_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_good |-> frame_done)
		else $error("frame_good without frame_done");

	// non-payload words carry zeroed payload fields
	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_strobe |->
			payload_byte == 8'h00 && payload_index == 16'h0000 && !within_buffer)
		else $error("payload fields set without strobe");

	// kept flag follows the index against the buffer size
	a_within: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_strobe |->
			within_buffer == ({1'b0, payload_index} < 17'(BUFFER_BYTES)))
		else $error("within_buffer does not match payload_index");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_index) &&
			$stable(frame_done))
		else $error("stalled result changed");

endmodule

bind ubx_frame_parser ubx_checker u_checker (.*);

// ===== test/ubx_frame_checker.sv =====
// result checker for the binary frame parser: watches both channels and predicts every result
// depends on ubx_pkg
module ubx_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        payload_strobe,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_index,
	input  logic        within_buffer,
	input  logic        frame_done,
	input  logic        frame_good,
	input  logic [7:0]  msg_class,
	input  logic [7:0]  msg_id,
	input  logic [15:0] payload_length,
	input  logic [9:0]  stored_count,
	output int          fail_count,
	output int          pending
);
	import ubx_pkg::*;

	typedef enum logic [3:0] {
		HUNT_SYNC1, HUNT_SYNC2, WAIT_CLASS, WAIT_ID, WAIT_LEN_LO, WAIT_LEN_HI,
		WAIT_DATA, WAIT_CK_A, WAIT_CK_B
	} parse_phase_t;

	typedef struct packed {
		logic        strobe;
		logic [7:0]  data;
		logic [15:0] index;
		logic        kept;
		logic        done;
		logic        good;
		logic [7:0]  cls;
		logic [7:0]  ident;
		logic [15:0] length;
		logic [9:0]  stored;
	} parse_result_t;

	parse_phase_t  phase;
	logic [7:0]    cls_q, id_q, ck_a, ck_b;
	logic [15:0]   len_q, left_q, idx_q;
	parse_result_t parse_results_q[$];
	parse_result_t want;

	function automatic void add_sum(input logic [7:0] b);
		ck_a = ck_a + b;
		ck_b = ck_b + ck_a;
	endfunction

	// one received word through the frame state machine
	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		int unsigned   kept_total;
		r = '0;
		case (phase)
			HUNT_SYNC2: begin
				if (b == SYNC_SECOND)
					phase = WAIT_CLASS;
				else if (b != SYNC_FIRST)
					phase = HUNT_SYNC1;
			end
			WAIT_CLASS: begin
				cls_q = b;
				ck_a = 8'h00;
				ck_b = 8'h00;
				add_sum(b);
				phase = WAIT_ID;
			end
			WAIT_ID: begin
				id_q = b;
				add_sum(b);
				phase = WAIT_LEN_LO;
			end
			WAIT_LEN_LO: begin
				len_q = {8'h00, b};
				add_sum(b);
				phase = WAIT_LEN_HI;
			end
			WAIT_LEN_HI: begin
				len_q = {b, len_q[7:0]};
				left_q = len_q;
				idx_q = 16'd0;
				add_sum(b);
				phase = (len_q == 16'd0) ? WAIT_CK_A : WAIT_DATA;
			end
			WAIT_DATA: begin
				add_sum(b);
				r.strobe = 1'b1;
				r.data = b;
				r.index = idx_q;
				r.kept = (idx_q < BUFFER_BYTES);
				if (idx_q != 16'hFFFF)
					idx_q = idx_q + 16'd1;
				left_q = left_q - 16'd1;
				if (left_q == 16'd0)
					phase = WAIT_CK_A;
			end
			WAIT_CK_A: phase = (b == ck_a) ? WAIT_CK_B : HUNT_SYNC1;
			WAIT_CK_B: begin
				r.done = 1'b1;
				r.good = (b == ck_b);
				phase = HUNT_SYNC1;
			end
			default: phase = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
		endcase
		kept_total = (idx_q > BUFFER_BYTES) ? BUFFER_BYTES : idx_q;
		r.cls = cls_q;
		r.ident = id_q;
		r.length = len_q;
		r.stored = kept_total[9:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = HUNT_SYNC1;
			cls_q = 8'h00;
			id_q = 8'h00;
			len_q = 16'd0;
			left_q = 16'd0;
			idx_q = 16'd0;
			ck_a = 8'h00;
			ck_b = 8'h00;
			parse_results_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (parse_results_q.size() == 0) begin
					$display("%0t: result word with none expected", $time);
					fail_count++;
				end else begin
					want = parse_results_q.pop_front();
					check_field("payload_strobe", want.strobe, payload_strobe);
					check_field("payload_byte", want.data, payload_byte);
					check_field("payload_index", want.index, payload_index);
					check_field("within_buffer", want.kept, within_buffer);
					check_field("frame_done", want.done, frame_done);
					check_field("frame_good", want.good, frame_good);
					check_field("msg_class", want.cls, msg_class);
					check_field("msg_id", want.ident, msg_id);
					check_field("payload_length", want.length, payload_length);
					check_field("stored_count", want.stored, stored_count);
				end
			end
			if (in_valid && !in_stall)
				parse_results_q.push_back(parse_byte(rx_byte));
			pending = parse_results_q.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// top of the frame parser testbench: clock, reset, byte stimulus and verdict
// depends on ubx_pkg, ubx_frame_parser and ubx_frame_checker
module testbench;
	import ubx_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_WORDS = 350;

	typedef enum int {CK_OK, CK_BAD_FIRST, CK_BAD_SECOND} ck_fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        payload_strobe;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic        within_buffer;
	logic        frame_done;
	logic        frame_good;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [15:0] payload_length;
	logic [9:0]  stored_count;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int words_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;

	// running fletcher sums of the frame being built
	logic [7:0] frame_sum_a, frame_sum_b;

	ubx_frame_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_strobe (payload_strobe),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.within_buffer  (within_buffer),
		.frame_done     (frame_done),
		.frame_good     (frame_good),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.stored_count   (stored_count)
	);

	ubx_frame_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_strobe (payload_strobe),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.within_buffer  (within_buffer),
		.frame_done     (frame_done),
		.frame_good     (frame_good),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.stored_count   (stored_count),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard: a hung handshake ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver side: random stalls, or one long hold-off when asked for
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// offer one word, idling first at random, and wait until it is taken
	task automatic put_word(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// word that is covered by the frame check bytes
	task automatic put_summed(input logic [7:0] b);
		frame_sum_a = frame_sum_a + b;
		frame_sum_b = frame_sum_b + frame_sum_a;
		put_word(b);
	endtask

	// whole frame with random payload; a fault flips bits of one check byte
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] ident,
			input logic [15:0] len, input ck_fault_t fault);
		logic [7:0] flip;
		flip = 8'($urandom_range(1, 255));
		put_word(SYNC_FIRST);
		put_word(SYNC_SECOND);
		frame_sum_a = 8'h00;
		frame_sum_b = 8'h00;
		put_summed(cls);
		put_summed(ident);
		put_summed(len[7:0]);
		put_summed(len[15:8]);
		for (int i = 0; i < len; i++)
			put_summed(8'($urandom_range(0, 255)));
		put_word((fault == CK_BAD_FIRST) ? frame_sum_a ^ flip : frame_sum_a);
		put_word((fault == CK_BAD_SECOND) ? frame_sum_b ^ flip : frame_sum_b);
	endtask

	// line noise never carries the second sync byte, so it cannot open a frame
	// with a random length that would swallow the rest of the stream
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == SYNC_SECOND);
		return b;
	endfunction

	// one random unit: mostly good frames, some noise, broken sync and bad sums
	task automatic send_random_unit();
		int        pick;
		int        fault_pick;
		logic [15:0] len;
		ck_fault_t fault;
		pick = $urandom_range(0, 99);
		fault_pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 12)) :
			16'($urandom_range(13, 48));
		fault = (fault_pick < 8) ? CK_BAD_FIRST : (fault_pick < 16) ? CK_BAD_SECOND : CK_OK;
		if (pick < 12) begin
			// idle line noise
			repeat ($urandom_range(1, 3)) put_word(noise_byte());
		end else if (pick < 20) begin
			// sync byte followed by something else
			put_word(SYNC_FIRST);
			put_word(noise_byte());
		end else begin
			// a repeated first sync byte now and then
			if (pick < 27)
				put_word(SYNC_FIRST);
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, fault);
		end
	endtask

	// stop offering words until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		int target;
		idle_tab = '{0, 60, 0, 26};
		stall_tab = '{0, 0, 60, 26};
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray bytes at both extremes, sync then junk
		put_word(8'h00);
		put_word(8'hFF);
		put_word(SYNC_FIRST);
		put_word(8'h00);
		// repeated sync into a zero-length frame
		put_word(SYNC_FIRST);
		send_frame(8'hFF, 8'h00, 16'd0, CK_OK);
		// second check byte wrong: done without good
		send_frame(8'h01, 8'h07, 16'd1, CK_BAD_SECOND);
		// first check byte wrong: frame dropped silently
		send_frame(8'h06, 8'h01, 16'd0, CK_BAD_FIRST);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			// long receiver hold-off while words keep coming, so the queue fills
			if (p == 0)
				hold_len = 60;
			// one frame past the buffer end, so later bytes are not kept
			if (p == 3)
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(530 + $urandom_range(0, 20)), CK_OK);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target)
				send_random_unit();
			drain();
		end

		// let any stray extra result show up
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
